// ----- src/pfc_pkg.sv -----
// Shared types and constants for the Playfair digraph cipher core.
package pfc_pkg;

  // Input word: one raw text byte and its end-of-text mark.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_word_t;

  // Result word: one substituted pair plus its status flags.
  typedef struct packed {
    logic [6:0] first_letter;
    logic [6:0] second_letter;
    logic       pair_valid;
    logic       letter_missing;
    logic       end_of_text;
  } out_word_t;

  // Letter codes run A=0 .. Z=25 in five bits.
  typedef logic [4:0] code_t;

  // Row or column position inside the 5x5 square.
  typedef logic [2:0] pos_t;

  // The square as rows of five letter codes, column 0 in the lowest bits.
  typedef logic [4:0][4:0][4:0] square_t;

  // Result of looking up one letter in the square.
  typedef struct packed {
    pos_t row;
    pos_t col;
    logic found;
  } loc_t;

  localparam int unsigned SqDim = 5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ENCRYPT_MODE = 3'd0;
  localparam logic [2:0] CFG_SQUARE_ROW_0 = 3'd1;
  localparam logic [2:0] CFG_SQUARE_ROW_4 = 3'd5;

  // Letter codes with a special role.
  localparam code_t CODE_I = 5'd8;
  localparam code_t CODE_J = 5'd9;
  localparam code_t CODE_X = 5'd23;

  // ASCII bounds and offsets.
  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
  localparam logic [6:0] ASCII_A_7     = 7'd65;

  // Reset square: ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ.
  localparam logic [24:0] SQUARE_ROW_0_RST = 25'd4294688;
  localparam logic [24:0] SQUARE_ROW_1_RST = 25'd10755269;
  localparam logic [24:0] SQUARE_ROW_2_RST = 25'd16201099;
  localparam logic [24:0] SQUARE_ROW_3_RST = 25'd21613104;
  localparam logic [24:0] SQUARE_ROW_4_RST = 25'd27025109;

endpackage

// ----- src/pfc_locate.sv -----
// Finds the first row-major position of a letter code in the square.
module pfc_locate (
  input  pfc_pkg::square_t square,
  input  pfc_pkg::code_t   code,
  output pfc_pkg::loc_t    loc
);
  import pfc_pkg::*;

  // Compare all 25 cells in parallel; scan backward so the first match wins.
  always_comb begin
    loc = '0;
    for (int r = SqDim - 1; r >= 0; r--) begin
      for (int c = SqDim - 1; c >= 0; c--) begin
        if (square[r][c] == code) begin
          loc.row   = pos_t'(r);
          loc.col   = pos_t'(c);
          loc.found = 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/playfair_digraph_cipher_core.sv -----
// Top level of the Playfair digraph cipher core.
// The core takes one text byte per cycle when not stalled and returns at most one word per
// byte: a substituted pair, or an end-of-text word. Throughput is one byte per clock while
// the result side does not stall; a result is registered first in the pairing stage and
// then in the square lookup and substitution stage. Stall on the result side propagates to
// in_stall within the same cycle. The square and the mode are taken from configuration and
// should be written only while no words are in flight.
module playfair_digraph_cipher_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfc_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_data
);
  import pfc_pkg::*;

  // Configuration registers.
  logic    encrypt_mode_r;
  square_t square_r;

  // Pending letter.
  code_t held_letter_r, held_letter_nxt;
  logic  held_valid_r, held_valid_nxt;

  // Pairing stage.
  logic  s1_valid_r;
  code_t s1_a_r, s1_b_r;
  logic  s1_pair_r, s1_last_r;

  // Result stage.
  logic      out_valid_r;
  out_word_t out_r, out_nxt;

  logic  in_accept, out_ready, s1_ready, s1_load;
  logic  is_letter, have_pair, emit;
  code_t letter_code, pair_a, pair_b;
  loc_t  loc_a, loc_b;
  code_t sub_a, sub_b;

  // Wrapping step along a row or column.
  function automatic pos_t step_pos(input pos_t p, input logic fwd);
    pos_t q;
    if (fwd) begin
      q = (p == pos_t'(SqDim - 1)) ? '0 : p + pos_t'(1);
    end else begin
      q = (p == '0) ? pos_t'(SqDim - 1) : p - pos_t'(1);
    end
    return q;
  endfunction

  // Handshake: each stage moves when the one after it has room.
  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encrypt_mode_r <= 1'b1;
      square_r[0]    <= SQUARE_ROW_0_RST;
      square_r[1]    <= SQUARE_ROW_1_RST;
      square_r[2]    <= SQUARE_ROW_2_RST;
      square_r[3]    <= SQUARE_ROW_3_RST;
      square_r[4]    <= SQUARE_ROW_4_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ENCRYPT_MODE) begin
        encrypt_mode_r <= cfg_data[0];
      end else if (cfg_index >= CFG_SQUARE_ROW_0 && cfg_index <= CFG_SQUARE_ROW_4) begin
        square_r[cfg_index - CFG_SQUARE_ROW_0] <= cfg_data;
      end
    end
  end

  // Letter decode: fold case and map J onto I.
  always_comb begin
    logic [7:0] diff;
    diff      = '0;
    is_letter = 1'b0;
    if (in_data.char_in >= ASCII_UPPER_A && in_data.char_in <= ASCII_UPPER_Z) begin
      is_letter = 1'b1;
      diff      = in_data.char_in - ASCII_UPPER_A;
    end else if (in_data.char_in >= ASCII_LOWER_A && in_data.char_in <= ASCII_LOWER_Z) begin
      is_letter = 1'b1;
      diff      = in_data.char_in - ASCII_LOWER_A;
    end
    letter_code = (diff[4:0] == CODE_J) ? CODE_I : diff[4:0];
  end

  // Pairing: join with the held letter, or pad with X on the last byte.
  always_comb begin
    held_letter_nxt = held_letter_r;
    held_valid_nxt  = held_valid_r;
    have_pair       = 1'b0;
    pair_a          = '0;
    pair_b          = '0;
    if (is_letter) begin
      if (held_valid_r) begin
        pair_a          = held_letter_r;
        pair_b          = letter_code;
        have_pair       = 1'b1;
        held_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
      end else begin
        held_letter_nxt = letter_code;
        held_valid_nxt  = 1'b1;
      end
    end
    if (in_data.last_char && !have_pair && held_valid_nxt) begin
      pair_a    = held_letter_nxt;
      pair_b    = CODE_X;
      have_pair = 1'b1;
    end
    if (in_data.last_char) begin
      held_valid_nxt  = 1'b0;
      held_letter_nxt = '0;
    end
    emit = have_pair || in_data.last_char;
  end

  assign s1_load = in_accept && emit;

  // Held letter and pairing stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_letter_r <= '0;
      held_valid_r  <= 1'b0;
      s1_valid_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        held_letter_r <= held_letter_nxt;
        held_valid_r  <= held_valid_nxt;
      end
      if (s1_ready) begin
        s1_valid_r <= s1_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_a_r    <= pair_a;
      s1_b_r    <= pair_b;
      s1_pair_r <= have_pair;
      s1_last_r <= in_data.last_char;
    end
  end

  // Square lookup for both letters of the pair.
  pfc_locate u_locate_a (
    .square (square_r),
    .code   (s1_a_r),
    .loc    (loc_a)
  );

  pfc_locate u_locate_b (
    .square (square_r),
    .code   (s1_b_r),
    .loc    (loc_b)
  );

  // Substitution: row shift, column shift, or rectangle corners.
  always_comb begin
    if (loc_a.row == loc_b.row) begin
      sub_a = square_r[loc_a.row][step_pos(loc_a.col, encrypt_mode_r)];
      sub_b = square_r[loc_b.row][step_pos(loc_b.col, encrypt_mode_r)];
    end else if (loc_a.col == loc_b.col) begin
      sub_a = square_r[step_pos(loc_a.row, encrypt_mode_r)][loc_a.col];
      sub_b = square_r[step_pos(loc_b.row, encrypt_mode_r)][loc_b.col];
    end else begin
      sub_a = square_r[loc_a.row][loc_b.col];
      sub_b = square_r[loc_b.row][loc_a.col];
    end
  end

  // Result word; fields without a pair stay zero.
  always_comb begin
    out_nxt             = '0;
    out_nxt.end_of_text = s1_last_r;
    if (s1_pair_r) begin
      out_nxt.first_letter   = ASCII_A_7 + {2'b00, sub_a};
      out_nxt.second_letter  = ASCII_A_7 + {2'b00, sub_b};
      out_nxt.pair_valid     = 1'b1;
      out_nxt.letter_missing = !loc_a.found || !loc_b.found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_r <= out_nxt;
    end
  end

  // A word without a pair is only ever the end-of-text marker.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.pair_valid |-> out_r.end_of_text)
    else $error("pairless word without end of text");

  // A word without a pair carries zero letter fields and no missing flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.pair_valid |->
      out_r.first_letter == '0 && out_r.second_letter == '0 && !out_r.letter_missing)
    else $error("pairless word carries letter data");

  // Nothing stays pending after the last byte of a text.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.last_char |=> !held_valid_r)
    else $error("letter held across end of text");

  // A pair word always carries codes from the 'A' offset upward.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.pair_valid |->
      out_r.first_letter >= ASCII_A_7 && out_r.second_letter >= ASCII_A_7)
    else $error("substitute letter below offset");

  // A pairing-stage word blocked by a stalled result holds its content.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_ready |=> s1_valid_r && $stable(s1_a_r) && $stable(s1_b_r))
    else $error("pairing stage lost a word under stall");

endmodule

// ----- dv/tb_playfair_digraph_cipher_core.sv -----
// Self-checking testbench for the Playfair digraph cipher core.
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher_core;
  import pfc_pkg::*;

  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;

  // Tracks the cipher state and the queue of result words still to arrive.
  class cipher_scoreboard;
    logic      enc;
    square_t   grid;
    logic      held_ok;
    code_t     held_code;
    out_word_t pending_pairs[$];
    int        errors;

    function new();
      enc       = 1'b1;
      grid      = {SQUARE_ROW_4_RST, SQUARE_ROW_3_RST, SQUARE_ROW_2_RST,
                   SQUARE_ROW_1_RST, SQUARE_ROW_0_RST};
      held_ok   = 1'b0;
      held_code = '0;
      errors    = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [24:0] value);
      if (idx == CFG_ENCRYPT_MODE) begin
        enc = value[0];
      end else if (idx >= CFG_SQUARE_ROW_0 && idx <= CFG_SQUARE_ROW_4) begin
        grid[idx - CFG_SQUARE_ROW_0] = value;
      end
    endfunction

    // Turns a byte into a letter code, folding case and J onto I.
    function bit decode(input logic [7:0] ch, output code_t code);
      code = '0;
      if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) begin
        code = code_t'(ch - ASCII_UPPER_A);
      end else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) begin
        code = code_t'(ch - ASCII_LOWER_A);
      end else begin
        return 1'b0;
      end
      if (code == CODE_J) code = CODE_I;
      return 1'b1;
    endfunction

    // First match in row-major order; a missing letter sits at the corner.
    function bit find_cell(input code_t code, output int r, output int c);
      bit hit;
      hit = 1'b0;
      r = 0;
      c = 0;
      for (int i = 0; i < SqDim; i++) begin
        for (int j = 0; j < SqDim; j++) begin
          if (!hit && grid[i][j] == code) begin
            hit = 1'b1;
            r = i;
            c = j;
          end
        end
      end
      return hit;
    endfunction

    function out_word_t substitute(input code_t a, input code_t b);
      int r1, c1, r2, c2, shift;
      bit f1, f2;
      code_t o1, o2;
      out_word_t res;
      shift = enc ? 1 : SqDim - 1;
      f1 = find_cell(a, r1, c1);
      f2 = find_cell(b, r2, c2);
      if (r1 == r2) begin
        o1 = grid[r1][(c1 + shift) % SqDim];
        o2 = grid[r2][(c2 + shift) % SqDim];
      end else if (c1 == c2) begin
        o1 = grid[(r1 + shift) % SqDim][c1];
        o2 = grid[(r2 + shift) % SqDim][c2];
      end else begin
        o1 = grid[r1][c2];
        o2 = grid[r2][c1];
      end
      res = '0;
      res.first_letter   = ASCII_A_7 + 7'(o1);
      res.second_letter  = ASCII_A_7 + 7'(o2);
      res.pair_valid     = 1'b1;
      res.letter_missing = !f1 || !f2;
      return res;
    endfunction

    // Advances the pairing state for one accepted input word.
    function void note_byte(input in_word_t w);
      bit is_letter, paired;
      code_t code, a, b;
      out_word_t res;
      is_letter = decode(w.char_in, code);
      paired = 1'b0;
      a = '0;
      b = '0;
      if (is_letter) begin
        if (held_ok) begin
          a = held_code;
          b = code;
          paired = 1'b1;
          held_ok = 1'b0;
        end else begin
          held_code = code;
          held_ok = 1'b1;
        end
      end
      if (w.last_char && !paired && held_ok) begin
        a = held_code;
        b = CODE_X;
        paired = 1'b1;
      end
      if (w.last_char) held_ok = 1'b0;
      if (paired || w.last_char) begin
        res = '0;
        if (paired) res = substitute(a, b);
        res.end_of_text = w.last_char;
        pending_pairs.push_back(res);
      end
    endfunction

    function void compare_field(input string name, input logic [6:0] want,
                                input logic [6:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(input out_word_t got);
      out_word_t want;
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: result word expected none, actual %h", $time, got);
        return;
      end
      want = pending_pairs.pop_front();
      compare_field("first_letter", want.first_letter, got.first_letter);
      compare_field("second_letter", want.second_letter, got.second_letter);
      compare_field("pair_valid", 7'(want.pair_valid), 7'(got.pair_valid));
      compare_field("letter_missing", 7'(want.letter_missing), 7'(got.letter_missing));
      compare_field("end_of_text", 7'(want.end_of_text), 7'(got.end_of_text));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [24:0] cfg_data = '0;

  cipher_scoreboard cipher;
  square_t          current_square;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int unsigned      hold_req = 0;
  int unsigned      hold_seen = 0;
  int               hold_left = 0;
  logic [7:0]       border_bytes [6] = '{8'd64, 8'd91, 8'd96, 8'd123, 8'd0, 8'd255};

  playfair_digraph_cipher_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every accepted word on either channel goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) cipher.note_byte(in_data);
      if (out_valid && !out_stall) cipher.check_result(out_data);
    end
  end

  // Offers one word, after a random gap, and returns once it is accepted.
  task automatic send_byte(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s, input logic ends);
    in_word_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.char_in   = s[i];
      w.last_char = ends && (i == s.len() - 1);
      send_byte(w);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (cipher.pending_pairs.size() != 0);
  endtask

  // Writes the mode and all five square rows back to back.
  task automatic load_config(input logic enc, input square_t sq);
    logic [24:0] value;
    for (int idx = CFG_ENCRYPT_MODE; idx <= CFG_SQUARE_ROW_4; idx++) begin
      value = (idx == CFG_ENCRYPT_MODE) ? 25'(enc) : sq[idx - CFG_SQUARE_ROW_0];
      cfg_valid <= 1'b1;
      cfg_index <= 3'(idx);
      cfg_data  <= value;
      do @(posedge clk); while (!cfg_ready);
      cipher.set_reg(3'(idx), value);
    end
    cfg_valid <= 1'b0;
    current_square = sq;
  endtask

  // A proper key square: the 25 letters without J in random order.
  function automatic square_t keyed_square();
    code_t letters [25];
    code_t t;
    square_t sq;
    int k, j;
    k = 0;
    for (int c = 0; c < 26; c++) begin
      if (c != CODE_J) begin
        letters[k] = code_t'(c);
        k++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      j = $urandom_range(i);
      t = letters[i];
      letters[i] = letters[j];
      letters[j] = t;
    end
    for (int i = 0; i < 25; i++) sq[i / 5][i % 5] = letters[i];
    return sq;
  endfunction

  // A loose square with repeats, gaps and codes beyond Z.
  function automatic square_t mixed_square();
    square_t sq;
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        sq[r][c] = ($urandom_range(99) < 80) ? code_t'($urandom_range(25))
                                              : code_t'($urandom_range(31));
      end
    end
    return sq;
  endfunction

  // Mostly letters, some drawn from the square, in either case; some raw noise.
  function automatic logic [7:0] pick_byte(input square_t sq);
    int roll;
    code_t c;
    roll = $urandom_range(99);
    if (roll < 15) return 8'($urandom_range(255));
    if (roll < 55) c = sq[$urandom_range(4)][$urandom_range(4)];
    else c = code_t'($urandom_range(25));
    if (c > 25) c = code_t'($urandom_range(25));
    return ($urandom_range(1) ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(c);
  endfunction

  // Random texts of n_items bytes, with an optional hold-off and drain pause.
  task automatic run_text(input int n_items, input int hold_at, input int pause_at);
    in_word_t w;
    int counted;
    bit hold_done, pause_done;
    counted = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    while (counted < n_items) begin
      if (counted == hold_at && !hold_done) begin
        hold_req <= hold_req + 1;
        hold_done = 1'b1;
      end
      if (counted == pause_at && !pause_done) begin
        wait_drained();
        pause_done = 1'b1;
      end
      w.char_in   = pick_byte(current_square);
      w.last_char = ($urandom_range(99) < 4);
      send_byte(w);
      counted++;
    end
  endtask

  initial begin
    in_word_t w;
    square_t sq;
    logic enc;
    int n_items, hold_at, pause_at;
    cipher = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texts under the reset square and mode.
    send_idle_pct = 10;
    recv_stall_pct <= 73;
    send_text("AB", 1'b0);
    send_text("AF", 1'b0);
    send_text("EA", 1'b0);
    send_text("VA", 1'b0);
    send_text("aj", 1'b0);
    send_text("LL", 1'b0);
    foreach (border_bytes[i]) begin
      w.char_in   = border_bytes[i];
      w.last_char = 1'b0;
      send_byte(w);
    end
    send_text("Zz", 1'b0);
    send_text("Q", 1'b1);
    send_text("!", 1'b1);
    send_text("MN", 1'b1);
    send_text("K", 1'b1);
    send_text("P!", 1'b1);
    send_text("X", 1'b1);

    // Random texts under a series of squares, modes and idle patterns.
    for (int seg = 0; seg < 7; seg++) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      n_items  = 250;
      hold_at  = -1;
      pause_at = -1;
      case (seg)
        0: begin enc = 1'b1; sq = keyed_square(); end
        1: begin enc = 1'b0; sq = '0; n_items = 80; end
        2: begin enc = 1'b0; sq = keyed_square(); pause_at = 120; end
        3: begin enc = 1'b1; sq = mixed_square(); end
        4: begin enc = 1'b1; sq = '1; n_items = 80; end
        5: begin enc = 1'b1; sq = keyed_square(); hold_at = 60; end
        default: begin enc = 1'b0; sq = mixed_square(); end
      endcase
      if (seg < 2) begin
        send_idle_pct = 10;
        recv_stall_pct <= 73;
      end else if (seg < 5) begin
        send_idle_pct = 73;
        recv_stall_pct <= 10;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct <= 0;
      end
      load_config(enc, sq);
      run_text(n_items, hold_at, pause_at);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (cipher.errors == 0 && cipher.pending_pairs.size() == 0) begin
      $display("playfair_digraph_cipher_core regression: pass");
    end else begin
      $display("playfair_digraph_cipher_core regression: fail");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("playfair_digraph_cipher_core regression: fail");
    $finish;
  end

endmodule
